/* hw/rtl/multi_queue_shared_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-queue shared buffer
// Define ASSERT_OFF to compile every check to nothing.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MQSB_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define MQSB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define MQSB_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define MQSB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

/* hw/rtl/mqsb_pkg.sv */
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and codes of the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_EMPTY    = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic fetch;
		logic commit;
	} mqsb_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_deq;
		logic out_free;
	} mqsb_sts_t;

endpackage

/* hw/rtl/mqsb_if.sv */
// ----------------------------------------------------------------------------
// mqsb_if
// Valid/ready channels for commands and responses.
// ----------------------------------------------------------------------------
interface mqsb_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic        [2:0]  queue_id;
	logic signed [31:0] push_data;

	modport source (output valid, output cmd, output queue_id, output push_data,
		input ready);
	modport sink (input valid, input cmd, input queue_id, input push_data,
		output ready);
endinterface

interface mqsb_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] pop_data;

	modport source (output valid, output status, output pop_data, input ready);
	modport sink (input valid, input status, input pop_data, output ready);
endinterface

/* hw/rtl/multi_queue_shared_buffer.sv */
// An enqueue is accepted, looks up its pointers and commits; a dequeue also
// fetches its head slot first. The steps follow the registered reads of the
// pointer and link stores done one after another; a commit waits for a free
// response register. A new command is taken while the previous response waits
// in its register. Reset clears the free list pointer, the fill mark and the
// queue valid bits at once; the slot and link stores need no clearing pass.
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// FIFO queues sharing one slot store through linked lists and a free list.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_assert.svh"

module multi_queue_shared_buffer
	import mqsb_pkg::*;
#(
	parameter int SLOTS  = 64,
	parameter int QUEUES = 8
) (
	input logic        clk,
	input logic        arst_n,
	mqsb_req_if.sink   req,
	mqsb_rsp_if.source rsp
);

	mqsb_ctl_t ctl;
	mqsb_sts_t sts;

	logic req_xfer;
	logic rsp_fail;
	logic deq_xfer;

	mqsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	mqsb_datapath #(
		.SLOTS  (SLOTS),
		.QUEUES (QUEUES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (req.cmd),
		.queue_id  (req.queue_id),
		.push_data (req.push_data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (rsp.status),
		.pop_data  (rsp.pop_data)
	);

	assign req_xfer = req.valid && req.ready;
	assign rsp_fail = rsp.valid && (rsp.status != STATUS_OK);
	assign deq_xfer = ctl.accept && (req.cmd == CMD_DEQ);

	// one command in flight at a time
	`MQSB_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_xfer, !req.ready, "taken while busy")

	// failed operations return no data
	`MQSB_ASSERT_IMP(a_fail_zero, clk, arst_n, rsp_fail, rsp.pop_data == '0, "data on failure")

	// a dequeue cannot commit before its head slot is fetched
	`MQSB_ASSERT_NEXT(a_deq_fetch, clk, arst_n, deq_xfer, !ctl.commit, "dequeue skipped fetch")

endmodule

/* hw/rtl/mqsb_ctrl.sv */
// ----------------------------------------------------------------------------
// mqsb_ctrl
// Sequencer: accept, look up pointers, fetch the head slot on a dequeue, commit.
// ----------------------------------------------------------------------------
module mqsb_ctrl
	import mqsb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  mqsb_sts_t sts,
	output mqsb_ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_FETCH,
		S_HOLD
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				ctl.accept = in_valid;
				if (in_valid)
					state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				// dequeue needs the head slot's link and data first
				if (sts.is_deq) begin
					ctl.fetch = 1'b1;
					state_d   = S_FETCH;
				end else begin
					ctl.commit = sts.out_free;
					state_d    = sts.out_free ? S_IDLE : S_HOLD;
				end
			end
			S_FETCH, S_HOLD: begin
				ctl.commit = sts.out_free;
				state_d    = sts.out_free ? S_IDLE : S_HOLD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

/* hw/rtl/mqsb_datapath.sv */
// ----------------------------------------------------------------------------
// mqsb_datapath
// Slot, link and pointer stores, free list and response register.
// ----------------------------------------------------------------------------
module mqsb_datapath
	import mqsb_pkg::*;
#(
	parameter int SLOTS  = 64,
	parameter int QUEUES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mqsb_ctl_t          ctl,
	output mqsb_sts_t          sts,
	input  logic               cmd,
	input  logic        [2:0]  queue_id,
	input  logic signed [31:0] push_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [1:0]  status,
	output logic signed [31:0] pop_data
);

	localparam int PW   = $clog2(SLOTS + 1);
	localparam int SW   = $clog2(SLOTS);
	localparam int QW   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int QCMP = 9;
	localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

	logic signed [31:0] data_mem [SLOTS];
	logic [PW-1:0]      link_mem [SLOTS];
	logic [PW-1:0]      head_mem [QUEUES];
	logic [PW-1:0]      tail_mem [QUEUES];

	// control state
	logic [PW-1:0]     free_head_q;
	logic [PW-1:0]     fill_q;
	logic [QUEUES-1:0] nonempty_q;
	logic              out_valid_q;

	// operation registers
	logic               cmd_q;
	logic [QW-1:0]      qidx_q;
	logic               ne_q;
	logic               qok_q;
	logic               fresh_q;
	logic signed [31:0] data_q;
	logic [PW-1:0]      head_rd_q;
	logic [PW-1:0]      tail_rd_q;
	logic [PW-1:0]      link_rd_q;
	logic signed [31:0] data_rd_q;
	status_t            out_status_q;
	logic signed [31:0] out_pop_q;

	logic [QW-1:0] qidx_in;
	logic          qok_in;
	logic [SW-1:0] link_raddr;
	logic          enq_ok;
	logic          deq_ok;
	logic          last;
	logic          out_free;
	status_t       status_d;

	assign qidx_in = QW'(queue_id);
	assign qok_in  = QCMP'(queue_id) < QCMP'(QUEUES);

	assign enq_ok   = (cmd_q == CMD_ENQ) && qok_q && (free_head_q != NULL_PTR);
	assign deq_ok   = (cmd_q == CMD_DEQ) && ne_q;
	assign last     = (head_rd_q == tail_rd_q);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (cmd_q == CMD_DEQ)
			status_d = deq_ok ? STATUS_OK : STATUS_EMPTY;
		else
			status_d = enq_ok ? STATUS_OK : STATUS_OVERFLOW;
	end

	assign sts.is_deq   = (cmd_q == CMD_DEQ);
	assign sts.out_free = out_free;

	// latch the operation on transfer
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= cmd;
			qidx_q  <= qidx_in;
			qok_q   <= qok_in;
			ne_q    <= qok_in && nonempty_q[qidx_in];
			data_q  <= push_data;
			fresh_q <= (free_head_q >= fill_q);
		end
	end

	// queue pointer stores
	always_ff @(posedge clk) begin
		if (ctl.accept)
			head_rd_q <= head_mem[qidx_in];
		if (ctl.commit && enq_ok && !ne_q)
			head_mem[qidx_q] <= free_head_q;
		else if (ctl.commit && deq_ok && !last)
			head_mem[qidx_q] <= link_rd_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept)
			tail_rd_q <= tail_mem[qidx_in];
		if (ctl.commit && enq_ok)
			tail_mem[qidx_q] <= free_head_q;
	end

	// link store: free slot on transfer, head slot on fetch
	assign link_raddr = ctl.fetch ? head_rd_q[SW-1:0] : free_head_q[SW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.accept || ctl.fetch)
			link_rd_q <= link_mem[link_raddr];
		// enqueue links behind the old tail, dequeue links onto the free list
		if (ctl.commit && enq_ok && ne_q)
			link_mem[tail_rd_q[SW-1:0]] <= free_head_q;
		else if (ctl.commit && deq_ok)
			link_mem[head_rd_q[SW-1:0]] <= free_head_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.fetch)
			data_rd_q <= data_mem[head_rd_q[SW-1:0]];
		if (ctl.commit && enq_ok)
			data_mem[free_head_q[SW-1:0]] <= data_q;
	end

	// free list; slots at or above the fill mark have never been used, and the
	// free head steps to the next slot up instead of reading their link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fill_q      <= '0;
			nonempty_q  <= '0;
		end else if (ctl.commit) begin
			if (enq_ok) begin
				nonempty_q[qidx_q] <= 1'b1;
				if (fresh_q) begin
					free_head_q <= free_head_q + PW'(1);
					fill_q      <= fill_q + PW'(1);
				end else begin
					free_head_q <= link_rd_q;
				end
			end else if (deq_ok) begin
				free_head_q <= head_rd_q;
				if (last)
					nonempty_q[qidx_q] <= 1'b0;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.commit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_status_q <= status_d;
			out_pop_q    <= deq_ok ? data_rd_q : 32'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign pop_data  = out_pop_q;

endmodule

/* test/mqsb_checker.sv */
// ----------------------------------------------------------------------------
// mqsb_checker
// Watches the command and response channels of the multi-queue shared buffer.
// Keeps its own copy of the linked lists and the free list and works out the
// status and data due for each command. Compares every response with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module mqsb_checker
	import mqsb_pkg::*;
#(
	parameter int SLOTS  = 64,
	parameter int QUEUES = 8
) (
	input  logic clk,
	input  logic arst_n,
	mqsb_req_if  req,
	mqsb_rsp_if  rsp,
	input  logic sweep,
	output int   errors,
	output int   outstanding,
	output int   n_enq_ok,
	output int   n_deq_ok,
	output int   n_overflow,
	output int   n_empty
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PTR_W = $clog2(SLOTS + 1);
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

	typedef struct {
		status_t            status;
		logic signed [31:0] pop_data;
	} queue_rsp_t;

	queue_rsp_t rsp_due[$];

	logic [31:0]      slot_val  [SLOTS];
	logic [PTR_W-1:0] slot_next [SLOTS];
	logic [PTR_W-1:0] q_head    [QUEUES];
	logic [PTR_W-1:0] q_tail    [QUEUES];
	logic [PTR_W-1:0] free_ptr;

	function automatic bit is_null(input logic [PTR_W-1:0] p);
		return int'(p) >= SLOTS;
	endfunction

	task automatic flag(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic clear_lists();
		rsp_due.delete();
		for (int i = 0; i < SLOTS; i++) begin
			slot_val[i]  = '0;
			slot_next[i] = PTR_W'(i + 1);
		end
		for (int i = 0; i < QUEUES; i++) begin
			q_head[i] = NULL_PTR;
			q_tail[i] = NULL_PTR;
		end
		free_ptr   = '0;
		errors     = 0;
		n_enq_ok   = 0;
		n_deq_ok   = 0;
		n_overflow = 0;
		n_empty    = 0;
	endtask

	// apply one command to the lists and queue up the response it earns
	task automatic apply_command(input logic cmd, input logic [2:0] q,
		input logic [31:0] data);
		queue_rsp_t       r;
		logic [PTR_W-1:0] s;
		r.status   = STATUS_OK;
		r.pop_data = '0;
		if (cmd == CMD_ENQ) begin
			if (int'(q) >= QUEUES || is_null(free_ptr)) begin
				r.status = STATUS_OVERFLOW;
				n_overflow++;
			end else begin
				s        = free_ptr;
				free_ptr = slot_next[s];
				if (is_null(q_head[q]))
					q_head[q] = s;
				// no link write through a null tail
				if (!is_null(q_tail[q]))
					slot_next[q_tail[q]] = s;
				slot_next[s] = NULL_PTR;
				q_tail[q]    = s;
				slot_val[s]  = data;
				n_enq_ok++;
			end
		end else begin
			if (int'(q) >= QUEUES || is_null(q_head[q])) begin
				r.status = STATUS_EMPTY;
				n_empty++;
			end else begin
				s = q_head[q];
				if (q_tail[q] == s)
					q_tail[q] = NULL_PTR;
				q_head[q]    = is_null(slot_next[s]) ? NULL_PTR : slot_next[s];
				// return the slot to the front of the free list
				slot_next[s] = free_ptr;
				free_ptr     = s;
				r.pop_data   = slot_val[s];
				slot_val[s]  = '1;
				n_deq_ok++;
			end
		end
		rsp_due.push_back(r);
	endtask

	task automatic check_response();
		queue_rsp_t e;
		if (rsp_due.size() == 0) begin
			flag($sformatf("response status %0d data %0d with no command outstanding",
				rsp.status, rsp.pop_data));
			return;
		end
		e = rsp_due.pop_front();
		if (rsp.status !== e.status)
			flag($sformatf("status %0d, predicted %0d", rsp.status, e.status));
		if (rsp.pop_data !== e.pop_data)
			flag($sformatf("pop_data %0d, predicted %0d", rsp.pop_data, e.pop_data));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_lists();
			outstanding <= 0;
		end else begin
			// a response always belongs to an earlier command, so retire first
			if (rsp.valid && rsp.ready)
				check_response();
			if (req.valid && req.ready)
				apply_command(req.cmd, req.queue_id, req.push_data);
			outstanding <= rsp_due.size();
		end
	end

	always @(posedge sweep) begin
		if (rsp_due.size() != 0)
			flag($sformatf("%0d responses never arrived", rsp_due.size()));
	end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives commands into the multi-queue shared buffer and drains its responses
// with random gaps on both channels. A directed opening walks the edge cases
// of the linked lists, then random rounds fill, drain or mix in turn so
// that overflow and empty queues come up often. Checking is in mqsb_checker.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mqsb_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int CHOKE_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 600000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic sweep  = 1'b0;

	int          mismatches;
	int          outstanding;
	int          n_enq_ok;
	int          n_deq_ok;
	int          n_overflow;
	int          n_empty;
	int unsigned cycle_count = 0;
	int          sent        = 0;
	bit          steady      = 1'b0;
	bit          choke_req   = 1'b0;

	mqsb_req_if req_ch ();
	mqsb_rsp_if rsp_ch ();

	multi_queue_shared_buffer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mqsb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.sweep       (sweep),
		.errors      (mismatches),
		.outstanding (outstanding),
		.n_enq_ok    (n_enq_ok),
		.n_deq_ok    (n_deq_ok),
		.n_overflow  (n_overflow),
		.n_empty     (n_empty)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, outstanding);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly back to back or short, now and then a long pause
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 11))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input logic cmd, input logic [2:0] q, input logic [31:0] data);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= cmd;
		req_ch.queue_id  <= q;
		req_ch.push_data <= data;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid     <= 1'b0;
			req_ch.push_data <= $urandom;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic hold_ready(input bit level, input int cycles);
		@(negedge clk);
		rsp_ch.ready <= level;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// response side
	initial begin
		int roll;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			roll = $urandom_range(0, 99);
			if (choke_req) begin
				// hold off long enough for the block to back up into the command side
				hold_ready(1'b0, CHOKE_CYCLES);
				choke_req = 1'b0;
			end else if (roll < 25) begin
				hold_ready(1'b1, $urandom_range(20, 120));
			end else if (roll < 90) begin
				hold_ready(1'b0, $urandom_range(1, 3));
				hold_ready(1'b1, $urandom_range(1, 6));
			end else begin
				hold_ready(1'b0, $urandom_range(10, 40));
				hold_ready(1'b1, $urandom_range(1, 6));
			end
		end
	end

	// command side
	initial begin
		int        left;
		int        round_len;
		int        enq_pct;
		int        rounds;
		logic [2:0] q_lo;
		logic [2:0] q_hi;
		logic       cmd;

		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_ENQ;
		req_ch.queue_id  = '0;
		req_ch.push_data = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// edge cases: empty queue, extremes of the data, last element, slot reuse
		send(CMD_DEQ, 3'd0, 32'h1234_5678);
		send(CMD_ENQ, 3'd0, 32'h7fff_ffff);
		send(CMD_ENQ, 3'd0, 32'h8000_0000);
		send(CMD_ENQ, 3'd7, 32'h0000_0000);
		send(CMD_ENQ, 3'd7, 32'hffff_ffff);
		send(CMD_ENQ, 3'd2, 32'h5555_5555);
		send(CMD_ENQ, 3'd5, 32'haaaa_aaaa);
		send(CMD_DEQ, 3'd0, 32'h0);
		send(CMD_DEQ, 3'd0, 32'h0);
		send(CMD_DEQ, 3'd0, 32'hffff_ffff);
		send(CMD_ENQ, 3'd0, 32'h0123_4567);
		send(CMD_DEQ, 3'd7, 32'h0);
		send(CMD_ENQ, 3'd7, 32'hdead_beef);
		send(CMD_DEQ, 3'd7, 32'h0);
		send(CMD_DEQ, 3'd7, 32'h0);
		send(CMD_DEQ, 3'd7, 32'h0);
		send(CMD_DEQ, 3'd2, 32'h0);
		send(CMD_DEQ, 3'd5, 32'h0);
		send(CMD_DEQ, 3'd0, 32'h0);
		send(CMD_ENQ, 3'd1, 32'h0000_0001);
		send(CMD_ENQ, 3'd3, 32'h8000_0001);
		send(CMD_ENQ, 3'd4, 32'h7fff_fffe);
		send(CMD_ENQ, 3'd6, 32'hfedc_ba98);

		// rounds alternate between filling, draining and a balanced mix
		left   = RANDOM_ITEMS;
		rounds = 0;
		while (left > 0) begin
			round_len = $urandom_range(40, 160);
			if (round_len > left)
				round_len = left;
			case (rounds % 3)
				0:       enq_pct = 85;
				1:       enq_pct = 15;
				default: enq_pct = $urandom_range(35, 65);
			endcase
			if ($urandom_range(0, 1)) begin
				q_lo = '0;
				q_hi = 3'd7;
			end else begin
				q_lo = 3'($urandom_range(0, 7));
				q_hi = (q_lo == 3'd7) ? q_lo : q_lo + 3'($urandom_range(0, 1));
			end
			steady = ($urandom_range(0, 3) == 0);
			if (rounds == 3)
				choke_req = 1'b1;
			for (int i = 0; i < round_len; i++) begin
				cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
				send(cmd, 3'($urandom_range(q_lo, q_hi)), pick_word());
			end
			left -= round_len;
			rounds++;
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		sweep <= 1'b1;
		@(posedge clk);

		$display("%0d commands: %0d enqueued, %0d dequeued, %0d overflows, %0d empty reads",
			sent, n_enq_ok, n_deq_ok, n_overflow, n_empty);
		$display("%0d random rounds, one %0d-cycle response hold-off under load",
			rounds, CHOKE_CYCLES);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* multi_queue_shared_buffer.f */
+incdir+hw/rtl
hw/rtl/mqsb_pkg.sv
hw/rtl/mqsb_if.sv
hw/rtl/mqsb_ctrl.sv
hw/rtl/mqsb_datapath.sv
hw/rtl/multi_queue_shared_buffer.sv
test/mqsb_checker.sv
test/tb.sv
